[hdl/fsc_pkg.sv]
// Shared types, constants and classification helpers for the format specifier classifier.
`timescale 1ns / 1ps

package fsc_pkg;

  localparam int unsigned DEF_MAX_TEXT_CHARS = 256;
  localparam logic [3:0]  MAX_CONV           = 4'd8;
  localparam logic [3:0]  MAX_CONV_RESET     = 4'd8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BIG_A = 8'h41;
  localparam logic [7:0] CH_BIG_E = 8'h45;
  localparam logic [7:0] CH_BIG_F = 8'h46;
  localparam logic [7:0] CH_BIG_G = 8'h47;
  localparam logic [7:0] CH_BIG_L = 8'h4c;
  localparam logic [7:0] CH_BIG_X = 8'h58;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_J     = 8'h6a;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7a;

  localparam logic [3:0] T_CHAR     = 4'd0;
  localparam logic [3:0] T_WCHAR    = 4'd1;
  localparam logic [3:0] T_SHORT    = 4'd2;
  localparam logic [3:0] T_INT      = 4'd3;
  localparam logic [3:0] T_LONG     = 4'd4;
  localparam logic [3:0] T_DOUBLE   = 4'd5;
  localparam logic [3:0] T_LDOUBLE  = 4'd6;
  localparam logic [3:0] T_PCHAR    = 4'd7;
  localparam logic [3:0] T_PSHORT   = 4'd8;
  localparam logic [3:0] T_PINT     = 4'd9;
  localparam logic [3:0] T_PLONG    = 4'd10;
  localparam logic [3:0] T_POINTER  = 4'd11;
  localparam logic [3:0] T_STRING   = 4'd12;
  localparam logic [3:0] T_WSTRING  = 4'd13;

  typedef enum logic [8:0] {
    PH_TEXT  = 9'b000000001,
    PH_PCT   = 9'b000000010,
    PH_FLAGS = 9'b000000100,
    PH_WIDTH = 9'b000001000,
    PH_PREC  = 9'b000010000,
    PH_H1    = 9'b000100000,
    PH_L1    = 9'b001000000,
    PH_LEN   = 9'b010000000,
    PH_WAIT  = 9'b100000000
  } phase_e;

  typedef enum logic [2:0] {
    LK_NONE = 3'd0,
    LK_H    = 3'd1,
    LK_HH   = 3'd2,
    LK_L    = 3'd3,
    LK_LL   = 3'd4,
    LK_BIGL = 3'd5
  } len_e;

  typedef enum logic [1:0] {
    CLS_CONV    = 2'd0,
    CLS_SKIP    = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e       kind;
    logic [3:0] code;
  } cls_t;

  function automatic logic fsc_is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic fsc_is_flag(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_HASH) ||
           (c == CH_ZERO) || (c == CH_SPACE);
  endfunction

  function automatic cls_t fsc_classify(logic [7:0] c, len_e lk);
    cls_t r;
    r.kind = CLS_CONV;
    r.code = T_CHAR;
    unique case (c)
      CH_C: r.code = (lk == LK_L) ? T_WCHAR : T_CHAR;
      CH_D, CH_I, CH_U, CH_O, CH_X, CH_BIG_X: begin
        if (lk == LK_HH)      r.code = T_CHAR;
        else if (lk == LK_L)  r.code = T_LONG;
        else if (lk == LK_H)  r.code = T_SHORT;
        else                  r.code = T_INT;
      end
      CH_A, CH_BIG_A, CH_E, CH_BIG_E, CH_F, CH_BIG_F, CH_G, CH_BIG_G:
        r.code = (lk == LK_BIGL) ? T_LDOUBLE : T_DOUBLE;
      CH_N: begin
        if (lk == LK_HH)      r.code = T_PCHAR;
        else if (lk == LK_L)  r.code = T_PLONG;
        else if (lk == LK_H)  r.code = T_PSHORT;
        else                  r.code = T_PINT;
      end
      CH_P: r.code = T_POINTER;
      CH_S: r.code = (lk == LK_L || lk == LK_BIGL) ? T_WSTRING : T_STRING;
      CH_M: r.kind = CLS_SKIP;
      default: r.kind = CLS_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

[hdl/fsc_char_if.sv]
// Input channel: one format string byte per transaction.
`timescale 1ns / 1ps

interface fsc_char_if import fsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

[hdl/fsc_res_if.sv]
// Result channel: one classified conversion or end-of-string report per transaction.
`timescale 1ns / 1ps

interface fsc_res_if import fsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       conv_valid;
  logic [3:0] conv_type;
  logic [2:0] conv_slot;
  logic       done_res;
  logic [3:0] conv_count;

  modport source (output valid, output conv_valid, output conv_type, output conv_slot,
                  output done_res, output conv_count, input ready);
  modport sink   (input valid, input conv_valid, input conv_type, input conv_slot,
                  input done_res, input conv_count, output ready);
endinterface

[hdl/fsc_cfg_if.sv]
// Configuration write channel for the conversion limit register.
`timescale 1ns / 1ps

interface fsc_cfg_if import fsc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] max_conversions;

  modport source (output valid, output max_conversions, input ready);
  modport sink   (input valid, input max_conversions, output ready);
endinterface

[hdl/format_specifier_classifier_unit.sv]
// Top level: printf format string scanner that classifies each conversion.
//
// text_i takes one byte of a format string per transaction; a zero byte ends
// the string. res_o gives one transaction for each recognized conversion
// (conv_valid=1 with type and slot) and one with done_res=1 when a string
// ends: at the zero byte, at the MAX_TEXT_CHARS-th byte, or when the
// conversion count reaches max_conversions capped at MAX_CONV; a done_res on
// a byte that is a conversion shares that byte's transaction. Bytes that
// cause no result give no transaction. After an early end, bytes are
// dropped up to the zero byte. cfg_i writes max_conversions (reset 8); it is
// always ready and should be written only while no bytes are in flight.
// A byte passes the input register, then the phase logic into the result
// register. Throughput: one byte per cycle while res_o does not stall.
// Reset clears the input and result valid flags, the phase, the length kind,
// the count, the byte position and sets the limit to 8. When res_o stalls,
// the input register holds a byte that has a result, and text_i.ready drops
// once that register is full; bytes with no result keep flowing.
`timescale 1ns / 1ps

module format_specifier_classifier_unit import fsc_pkg::*; #(
  parameter int unsigned MAX_TEXT_CHARS = DEF_MAX_TEXT_CHARS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsc_char_if.sink   text_i,
  fsc_cfg_if.sink    cfg_i,
  fsc_res_if.source  res_o
);

  localparam int unsigned PosW = $clog2(MAX_TEXT_CHARS + 1);

  logic [3:0]      max_q;
  logic            s1_valid_q;
  logic [7:0]      s1_char_q;
  phase_e          ph_q, ph_d, ph_n;
  len_e            lk_q, lk_d, lk_n;
  logic [3:0]      cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d, pos_n;

  logic            out_valid_q;
  logic            conv_valid_q, done_q;
  logic [3:0]      type_q, count_q;
  logic [2:0]      slot_q;

  logic [3:0]      lim;
  logic            len_chk;
  cls_t            cls;
  logic            r_valid, r_done, done_nul, done_stop, emit;
  logic [3:0]      r_type, r_count;
  logic [2:0]      r_slot;
  logic            out_free, s1_fire;
  logic [7:0]      c;

  assign c        = s1_char_q;
  assign lim      = (max_q > MAX_CONV) ? MAX_CONV : max_q;
  assign out_free = !out_valid_q || res_o.ready;
  assign s1_fire  = s1_valid_q && (!emit || out_free);

  assign text_i.ready = !s1_valid_q || s1_fire;
  assign cfg_i.ready  = 1'b1;

  // spec byte decode
  always_comb begin
    ph_n    = ph_q;
    lk_n    = lk_q;
    len_chk = 1'b0;
    cls     = '{kind: CLS_SKIP, code: T_CHAR};
    priority if (ph_q == PH_TEXT) begin
      cls.kind = CLS_UNKNOWN;
    end else if (ph_q == PH_PCT && c == CH_PCT) begin
      ph_n = PH_TEXT;
    end else if ((ph_q == PH_PCT || ph_q == PH_FLAGS) && fsc_is_flag(c)) begin
      ph_n = PH_FLAGS;
    end else if (ph_q == PH_PCT || ph_q == PH_FLAGS || ph_q == PH_WIDTH) begin
      if (fsc_is_digit(c)) begin
        ph_n = PH_WIDTH;
      end else if (c == CH_DOT) begin
        ph_n = PH_PREC;
      end else begin
        len_chk = 1'b1;
      end
    end else if (ph_q == PH_PREC) begin
      len_chk = !fsc_is_digit(c);
    end else if (ph_q == PH_H1 || ph_q == PH_L1) begin
      if (c == ((ph_q == PH_H1) ? CH_H : CH_L)) begin
        lk_n = (ph_q == PH_H1) ? LK_HH : LK_LL;
        ph_n = PH_LEN;
      end else begin
        ph_n = PH_TEXT;
        cls  = fsc_classify(c, (ph_q == PH_H1) ? LK_H : LK_L);
      end
    end else begin
      ph_n = PH_TEXT;
      cls  = fsc_classify(c, lk_q);
    end

    if (len_chk) begin
      unique case (c)
        CH_H:     ph_n = PH_H1;
        CH_L:     ph_n = PH_L1;
        CH_BIG_L: begin
          lk_n = LK_BIGL;
          ph_n = PH_LEN;
        end
        CH_J, CH_T, CH_Z: begin
          lk_n = LK_NONE;
          ph_n = PH_LEN;
        end
        default: begin
          ph_n = PH_TEXT;
          cls  = fsc_classify(c, LK_NONE);
        end
      endcase
    end
  end

  // result and state update
  always_comb begin
    ph_d      = ph_q;
    lk_d      = lk_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    pos_n     = pos_q + PosW'(1);
    r_valid   = 1'b0;
    r_type    = T_CHAR;
    r_slot    = 3'd0;
    r_done    = 1'b0;
    r_count   = cnt_q;
    done_nul  = 1'b0;
    done_stop = 1'b0;
    emit      = 1'b0;
    priority if (ph_q == PH_WAIT) begin
      if (c == CH_NUL) begin
        ph_d  = PH_TEXT;
        lk_d  = LK_NONE;
        cnt_d = 4'd0;
        pos_d = '0;
      end
    end else if (cnt_q >= lim) begin
      emit   = 1'b1;
      r_done = 1'b1;
      if (c == CH_NUL) begin
        ph_d  = PH_TEXT;
        lk_d  = LK_NONE;
        cnt_d = 4'd0;
        pos_d = '0;
      end else begin
        ph_d = PH_WAIT;
      end
    end else begin
      ph_d = ph_n;
      lk_d = lk_n;
      if (cls.kind == CLS_CONV) begin
        r_valid = 1'b1;
        r_type  = cls.code;
        r_slot  = cnt_q[2:0];
        cnt_d   = cnt_q + 4'd1;
        done_stop = (cnt_d >= lim);
      end else if (cls.kind == CLS_UNKNOWN) begin
        lk_d = LK_NONE;
        if (c == CH_NUL) begin
          done_nul = 1'b1;
        end else if (c == CH_PCT) begin
          ph_d = PH_PCT;
        end else begin
          ph_d = PH_TEXT;
        end
      end
      if (ph_d == PH_TEXT) begin
        lk_d = LK_NONE;
      end
      pos_d = pos_n;
      if (!done_nul && !done_stop && pos_n >= PosW'(MAX_TEXT_CHARS)) begin
        done_stop = 1'b1;
      end
      r_done  = done_nul || done_stop;
      r_count = cnt_d;
      emit    = r_valid || r_done;
      if (done_nul) begin
        ph_d  = PH_TEXT;
        lk_d  = LK_NONE;
        cnt_d = 4'd0;
        pos_d = '0;
      end else if (done_stop) begin
        ph_d = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= MAX_CONV_RESET;
      s1_valid_q  <= 1'b0;
      ph_q        <= PH_TEXT;
      lk_q        <= LK_NONE;
      cnt_q       <= 4'd0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        max_q <= cfg_i.max_conversions;
      end
      if (text_i.valid && text_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        ph_q  <= ph_d;
        lk_q  <= lk_d;
        cnt_q <= cnt_d;
        pos_q <= pos_d;
      end
      if (s1_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      s1_char_q <= text_i.text_char;
    end
    if (s1_fire && emit) begin
      conv_valid_q <= r_valid;
      type_q       <= r_type;
      slot_q       <= r_slot;
      done_q       <= r_done;
      count_q      <= r_count;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.conv_valid = conv_valid_q;
  assign res_o.conv_type  = type_q;
  assign res_o.conv_slot  = slot_q;
  assign res_o.done_res   = done_q;
  assign res_o.conv_count = count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CONV)
    else $error("conversion count above limit");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_TEXT_CHARS))
    else $error("byte position past text limit");

  a_slot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && conv_valid_q) |-> (count_q == {1'b0, slot_q} + 4'd1))
    else $error("slot and count disagree");

  a_wait_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && ph_q == PH_WAIT) |=> !$rose(out_valid_q))
    else $error("result produced while skipping to end of string");
`endif

endmodule
